@@ rtl/bresenham_line_rasterizer_core_assert.svh @@
// Assertion macros for the line rasterizer RTL, used by the sequencer.
`ifndef BRESENHAM_LINE_RASTERIZER_CORE_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define BLR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line rasterizer assertion failed");
// Next-cycle implication, disabled during reset.
`define BLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line rasterizer assertion failed");
`else
`define BLR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/blr_pkg.sv @@
// Types, constants and helpers shared by the line rasterizer modules.
`default_nettype none
package blr_pkg;

    localparam int SCREEN_WIDTH = 64;
    localparam int COORD_W      = 6;
    localparam int ADDR_W       = 12;
    localparam int COLOR_W      = 8;
    localparam int GLYPH_W      = 16;
    localparam int ERR_W        = 8;

    // One line command.
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_y;
        logic [COLOR_W-1:0] line_color;
        logic [GLYPH_W-1:0] glyph_code;
    } t_line_cmd;

    // One pixel write.
    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] pixel_color;
        logic [GLYPH_W-1:0] pixel_glyph;
        logic               last_pixel;
    } t_pixel_wr;

    // Sequencer commands to the stepping unit.
    typedef struct packed {
        logic load;
        logic advance;
    } t_step_ctl;

    // Stepping unit status and current pixel.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_step_sts;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_EMIT
    } t_state;

    // Linear frame-buffer index of a pixel.
    function automatic logic [ADDR_W-1:0] pixel_addr(input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y);
        logic [ADDR_W-1:0] prod;
        prod = ADDR_W'(y) * ADDR_W'(SCREEN_WIDTH);
        return prod + ADDR_W'(x);
    endfunction

endpackage
`default_nettype wire

@@ rtl/blr_step.sv @@
// Bresenham stepping unit: setup of the walk and the shared error-term adder.
`default_nettype none
module blr_step (
    input  wire logic              i_clk,
    input  wire blr_pkg::t_line_cmd i_cmd,
    input  wire blr_pkg::t_step_ctl i_ctl,
    output blr_pkg::t_step_sts      o_sts
);
    import blr_pkg::*;

    // Walk state: major and minor coordinates, end of the major axis, error.
    logic               r_xmaj, n_xmaj;
    logic               r_neg, n_neg;
    logic [COORD_W-1:0] r_maj, n_maj;
    logic [COORD_W-1:0] r_min, n_min;
    logic [COORD_W-1:0] r_end, n_end;
    logic [ERR_W-1:0]   r_err, n_err;
    logic [ERR_W-1:0]   r_inc_lo, n_inc_lo;
    logic [ERR_W-1:0]   r_inc_hi, n_inc_hi;

    // Setup terms.
    logic [COORD_W:0]   dx, dy;
    logic [COORD_W-1:0] adx, ady, amaj, amin;
    logic               dx_neg, dy_neg, xmaj;
    logic               take_minor;
    logic [ERR_W-1:0]   err_add;

    always_comb begin
        dx     = {1'b0, i_cmd.end_x} - {1'b0, i_cmd.start_x};
        dy     = {1'b0, i_cmd.end_y} - {1'b0, i_cmd.start_y};
        dx_neg = dx[COORD_W];
        dy_neg = dy[COORD_W];
        adx    = dx_neg ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady    = dy_neg ? COORD_W'(-dy) : dy[COORD_W-1:0];
        xmaj   = (ady <= adx);
        amaj   = xmaj ? adx : ady;
        amin   = xmaj ? ady : adx;

        // The x-major walk steps minor on a non-negative error, y-major on a positive one.
        take_minor = r_xmaj ? !r_err[ERR_W-1] : (!r_err[ERR_W-1] && (r_err != '0));
        err_add    = take_minor ? r_inc_hi : r_inc_lo;

        n_xmaj   = r_xmaj;
        n_neg    = r_neg;
        n_maj    = r_maj;
        n_min    = r_min;
        n_end    = r_end;
        n_err    = r_err;
        n_inc_lo = r_inc_lo;
        n_inc_hi = r_inc_hi;

        if (i_ctl.load) begin
            // Start from the end point with the lower major coordinate.
            n_xmaj   = xmaj;
            n_neg    = dx_neg != dy_neg;
            n_inc_lo = ERR_W'({amin, 1'b0});
            n_inc_hi = ERR_W'({amin, 1'b0}) - ERR_W'({amaj, 1'b0});
            n_err    = ERR_W'({amin, 1'b0}) - ERR_W'(amaj);
            if (xmaj) begin
                n_maj = dx_neg ? i_cmd.end_x : i_cmd.start_x;
                n_min = dx_neg ? i_cmd.end_y : i_cmd.start_y;
                n_end = dx_neg ? i_cmd.start_x : i_cmd.end_x;
            end else begin
                n_maj = dy_neg ? i_cmd.end_y : i_cmd.start_y;
                n_min = dy_neg ? i_cmd.end_x : i_cmd.start_x;
                n_end = dy_neg ? i_cmd.start_y : i_cmd.end_y;
            end
        end else if (i_ctl.advance) begin
            n_maj = r_maj + COORD_W'(1);
            n_err = r_err + err_add;
            if (take_minor) begin
                n_min = r_neg ? (r_min - COORD_W'(1)) : (r_min + COORD_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_xmaj   <= n_xmaj;
        r_neg    <= n_neg;
        r_maj    <= n_maj;
        r_min    <= n_min;
        r_end    <= n_end;
        r_err    <= n_err;
        r_inc_lo <= n_inc_lo;
        r_inc_hi <= n_inc_hi;
    end

    // Current pixel in screen coordinates.
    always_comb begin
        o_sts.x    = r_xmaj ? r_maj : r_min;
        o_sts.y    = r_xmaj ? r_min : r_maj;
        o_sts.last = (r_maj == r_end);
    end

endmodule
`default_nettype wire

@@ rtl/blr_ctrl.sv @@
// Sequencer: command capture, walk control and the output handshake.
`default_nettype none
`include "bresenham_line_rasterizer_core_assert.svh"
module blr_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire blr_pkg::t_line_cmd i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output blr_pkg::t_line_cmd      o_cmd,
    output blr_pkg::t_step_ctl      o_ctl,
    input  wire blr_pkg::t_step_sts i_sts
);
    import blr_pkg::*;

    t_state    r_state, n_state;
    t_line_cmd r_cmd;
    logic      accept;

    assign accept = i_in_valid && !o_in_stall;
    assign o_cmd  = r_cmd;

    // Command register holds the item for the whole walk.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and step commands.
    always_comb begin
        n_state       = r_state;
        o_in_stall    = 1'b1;
        o_out_valid   = 1'b0;
        o_ctl.load    = 1'b0;
        o_ctl.advance = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_ctl.load = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (i_sts.last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ctl.advance = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `BLR_ASSERT_NEXT(a_accept_setup, i_clk, i_rst_n, accept, r_state == S_SETUP)
    `BLR_ASSERT_NEXT(a_setup_emit, i_clk, i_rst_n, r_state == S_SETUP, o_out_valid)
    `BLR_ASSERT_NEXT(a_hold_pixel, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(i_sts))
    `BLR_ASSERT_NEXT(a_last_done, i_clk, i_rst_n, o_out_valid && !i_out_stall && i_sts.last, !o_out_valid)

endmodule
`default_nettype wire

@@ rtl/bresenham_line_rasterizer_core.sv @@
// Top level of the Bresenham line rasterizer: one line command in, its pixel writes out.
// After a command is accepted, S_SETUP loads the walk and S_EMIT then offers the pixel writes.
// Throughput: one pixel write per cycle while not stalled, max(|dx|,|dy|)+1 writes per line;
// the shared error-term adder sets the pace.
// A new command is taken only after the last pixel of the previous line is delivered.
// Reset (synchronous, active low) returns the sequencer to idle and drops any line in progress.
`default_nettype none
module bresenham_line_rasterizer_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire blr_pkg::t_line_cmd i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output blr_pkg::t_pixel_wr      o_out_item
);
    import blr_pkg::*;

    t_line_cmd cmd;
    t_step_ctl ctl;
    t_step_sts sts;

    blr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .o_ctl       (ctl),
        .i_sts       (sts)
    );

    blr_step u_step (
        .i_clk (i_clk),
        .i_cmd (cmd),
        .i_ctl (ctl),
        .o_sts (sts)
    );

    // Pixel write assembled from the walk registers and the held command.
    always_comb begin
        o_out_item.pixel_x       = sts.x;
        o_out_item.pixel_y       = sts.y;
        o_out_item.pixel_address = pixel_addr(sts.x, sts.y);
        o_out_item.pixel_color   = cmd.line_color;
        o_out_item.pixel_glyph   = cmd.glyph_code;
        o_out_item.last_pixel    = sts.last;
    end

endmodule
`default_nettype wire

@@ bench/bresenham_line_rasterizer_core_chk.sv @@
`timescale 1ns / 100ps
// Checker for the line rasterizer: predicts every pixel write and compares it with the output.
module bresenham_line_rasterizer_core_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  blr_pkg::t_line_cmd i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  blr_pkg::t_pixel_wr i_out_item,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_pixel_count
);

    // Pixel writes predicted but not yet delivered, oldest first.
    blr_pkg::t_pixel_wr expected_pixels[$];
    blr_pkg::t_pixel_wr want;
    int                 mismatches   = 0;
    int                 pixels_seen  = 0;

    initial o_pending = 0;

    assign o_fail_count  = mismatches;
    assign o_pixel_count = pixels_seen;

    // Queue one predicted pixel write; the address wraps at 12 bits.
    function automatic void push_pixel(int px, int py, logic last, blr_pkg::t_line_cmd cmd);
        blr_pkg::t_pixel_wr w;
        w.pixel_x       = px[5:0];
        w.pixel_y       = py[5:0];
        w.pixel_address = 12'(px + py * blr_pkg::SCREEN_WIDTH);
        w.pixel_color   = cmd.line_color;
        w.pixel_glyph   = cmd.glyph_code;
        w.last_pixel    = last;
        expected_pixels.push_back(w);
    endfunction

    // Walk one line command and queue all of its pixel writes in delivery order.
    function automatic void rasterize_line(blr_pkg::t_line_cmd cmd);
        int x1, x2, y1, y2;
        int dx, dy, adx, ady;
        int step, err, px, py, stop, lo, hi;
        x1 = int'(cmd.start_x);
        x2 = int'(cmd.end_x);
        y1 = int'(cmd.start_y);
        y2 = int'(cmd.end_y);
        dx = x2 - x1;
        dy = y2 - y1;
        if (dx == 0) begin
            // Vertical line or single dot: walk y upward from the lower end.
            lo = (y1 < y2) ? y1 : y2;
            hi = (y1 < y2) ? y2 : y1;
            for (py = lo; py <= hi; py++) push_pixel(x1, py, py == hi, cmd);
        end else if (dy == 0) begin
            // Horizontal line: walk x upward from the lower end.
            lo = (x1 < x2) ? x1 : x2;
            hi = (x1 < x2) ? x2 : x1;
            for (px = lo; px <= hi; px++) push_pixel(px, y1, px == hi, cmd);
        end else begin
            adx  = (dx < 0) ? -dx : dx;
            ady  = (dy < 0) ? -dy : dy;
            step = ((dx < 0) == (dy < 0)) ? 1 : -1;
            if (ady <= adx) begin
                // Shallow line: x is major, minor step when the error is not negative.
                err = 2 * ady - adx;
                if (dx > 0) begin
                    px = x1; py = y1; stop = x2;
                end else begin
                    px = x2; py = y2; stop = x1;
                end
                push_pixel(px, py, px >= stop, cmd);
                while (px < stop) begin
                    px++;
                    if (err < 0) begin
                        err += 2 * ady;
                    end else begin
                        py  += step;
                        err += 2 * (ady - adx);
                    end
                    push_pixel(px, py, px >= stop, cmd);
                end
            end else begin
                // Steep line: y is major, minor step only when the error is positive.
                err = 2 * adx - ady;
                if (dy > 0) begin
                    px = x1; py = y1; stop = y2;
                end else begin
                    px = x2; py = y2; stop = y1;
                end
                push_pixel(px, py, py >= stop, cmd);
                while (py < stop) begin
                    py++;
                    if (err <= 0) begin
                        err += 2 * adx;
                    end else begin
                        px  += step;
                        err += 2 * (adx - ady);
                    end
                    push_pixel(px, py, py >= stop, cmd);
                end
            end
        end
    endfunction

    function automatic void check_field(string fname, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", fname, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Predict on every accepted command, compare on every accepted pixel write.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) rasterize_line(i_in_item);
            if (i_out_valid && !i_out_stall) begin
                pixels_seen++;
                if (expected_pixels.size() == 0) begin
                    $error("pixel write with nothing expected: x=%0d y=%0d",
                           i_out_item.pixel_x, i_out_item.pixel_y);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_x", want.pixel_x, i_out_item.pixel_x);
                    check_field("pixel_y", want.pixel_y, i_out_item.pixel_y);
                    check_field("pixel_address", want.pixel_address, i_out_item.pixel_address);
                    check_field("pixel_color", want.pixel_color, i_out_item.pixel_color);
                    check_field("pixel_glyph", want.pixel_glyph, i_out_item.pixel_glyph);
                    check_field("last_pixel", want.last_pixel, i_out_item.last_pixel);
                end
            end
            o_pending <= expected_pixels.size();
        end
    end

endmodule

@@ bench/bresenham_line_rasterizer_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the line rasterizer: drives line commands and pixel-write back-pressure.
module bresenham_line_rasterizer_core_tb;

    localparam int RST_CYCLES   = 7;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RAND_BLOCKS  = 20;
    localparam int BLOCK_LINES  = 20;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    blr_pkg::t_line_cmd in_item   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    blr_pkg::t_pixel_wr out_item;

    int fail_count;
    int pending;
    int pixel_count;
    int lines_sent    = 0;
    int hold_cnt      = 0;
    int stall_draw;
    int idle_cycles   = 0;
    bit send_idle_on  = 1'b1;
    bit take_idle_on  = 1'b1;

    always #5 clk = ~clk;

    bresenham_line_rasterizer_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    bresenham_line_rasterizer_core_chk u_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_item    (out_item),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_pixel_count (pixel_count)
    );

    // Receiver: after each accepted pixel write, stall for a random number of cycles.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_cnt  <= 0;
        end else if (out_valid && !out_stall) begin
            stall_draw = take_idle_on ? $urandom_range(0, 7) : 0;
            hold_cnt  <= stall_draw;
            out_stall <= (stall_draw != 0);
        end else if (hold_cnt > 1) begin
            hold_cnt <= hold_cnt - 1;
        end else if (hold_cnt == 1) begin
            hold_cnt  <= 0;
            out_stall <= 1'b0;
        end
    end

    // Watchdog: end the run if no item moves on either channel for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("bresenham_line_rasterizer_core_tb: done, errors");
                $finish;
            end
        end
    end

    function automatic blr_pkg::t_line_cmd make_line(int sx, int sy, int ex, int ey,
                                                     int col, int gly);
        blr_pkg::t_line_cmd c;
        c.start_x    = sx[5:0];
        c.start_y    = sy[5:0];
        c.end_x      = ex[5:0];
        c.end_y      = ey[5:0];
        c.line_color = col[7:0];
        c.glyph_code = gly[15:0];
        return c;
    endfunction

    function automatic int clip_coord(int v);
        return (v < 0) ? 0 : ((v > 63) ? 63 : v);
    endfunction

    // Random command mix: half arbitrary lines, the other half short, axis-aligned and dot commands.
    function automatic blr_pkg::t_line_cmd random_line();
        int kind, sx, sy, ex, ey, d;
        kind = $urandom_range(0, 19);
        sx   = $urandom_range(0, 63);
        sy   = $urandom_range(0, 63);
        ex   = $urandom_range(0, 63);
        ey   = $urandom_range(0, 63);
        if (kind >= 10 && kind < 15) begin
            d  = $urandom_range(0, 8);
            ex = clip_coord(sx + d - 4);
            d  = $urandom_range(0, 8);
            ey = clip_coord(sy + d - 4);
        end else if (kind >= 15 && kind < 17) begin
            ey = sy;
        end else if (kind >= 17 && kind < 19) begin
            ex = sx;
        end else if (kind == 19) begin
            ex = sx;
            ey = sy;
        end
        return make_line(sx, sy, ex, ey, $urandom, $urandom);
    endfunction

    // Offer one command after an optional gap and hold it until it is accepted.
    task automatic send_line(blr_pkg::t_line_cmd cmd);
        int gap;
        gap = send_idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= cmd;
        do @(posedge clk); while (in_stall);
        lines_sent++;
    endtask

    // Stop sending until every predicted pixel write has been delivered.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed commands: dots, screen-spanning edges, diagonals and error-term ties.
        send_line(make_line(0, 0, 0, 0, 8'h00, 16'h0000));
        send_line(make_line(63, 63, 63, 63, 8'hFF, 16'hFFFF));
        send_line(make_line(0, 0, 63, 0, 8'hAA, 16'hA5A5));
        send_line(make_line(63, 63, 0, 63, 8'h55, 16'h5A5A));
        send_line(make_line(0, 63, 0, 0, 8'hFF, 16'h0000));
        send_line(make_line(63, 0, 63, 63, 8'h00, 16'hFFFF));
        send_line(make_line(0, 0, 63, 63, 8'h0F, 16'h00FF));
        send_line(make_line(63, 0, 0, 63, 8'hF0, 16'hFF00));
        send_line(make_line(63, 63, 0, 0, 8'h81, 16'h8001));
        send_line(make_line(0, 0, 63, 20, 8'h7E, 16'h7FFE));
        send_line(make_line(63, 20, 0, 0, 8'h12, 16'h1234));
        send_line(make_line(0, 63, 63, 10, 8'h34, 16'hABCD));
        send_line(make_line(5, 0, 20, 63, 8'h56, 16'h3C3C));
        send_line(make_line(20, 63, 5, 0, 8'h78, 16'hC3C3));
        send_line(make_line(63, 0, 40, 63, 8'h9A, 16'h0F0F));
        send_line(make_line(10, 10, 12, 11, 8'hBC, 16'hF0F0));
        send_line(make_line(10, 10, 11, 12, 8'hDE, 16'h1111));
        send_line(make_line(0, 0, 1, 63, 8'h01, 16'h8000));
        send_line(make_line(0, 0, 63, 1, 8'h80, 16'h0001));
        send_line(make_line(30, 30, 31, 30, 8'h3C, 16'h7777));
        drain();

        // Random blocks, each with its own idling mix; some end by draining the block.
        for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            take_idle_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < BLOCK_LINES; n++) send_line(random_line());
            if (blk % 5 == 4) drain();
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d line commands: dots, axis-aligned, diagonal, shallow, steep.",
                 lines_sent);
        $display("%0d pixel writes were checked under random gaps and stalls.", pixel_count);
        if (fail_count == 0 && pending == 0) begin
            $display("bresenham_line_rasterizer_core_tb: done, clean");
        end else begin
            $display("bresenham_line_rasterizer_core_tb: done, errors");
        end
        $finish;
    end

endmodule
